[rtl/core/psvg_pkg.sv]
// Shared types, constants and helper functions for the polygon/star vertex generator.
`default_nettype none

package psvg_pkg;

    localparam int MAX_SIDES  = 32;
    localparam int COORD_W    = 14;
    localparam int IDX_W      = 5;
    localparam int SIDES_W    = 6;
    localparam int PCT_W      = 7;
    localparam int TRIG_W     = 17;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SIDE_COUNT = 2'd0,
        REG_STAR_DEPTH = 2'd1
    } cfg_reg_t;

    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
    localparam logic [PCT_W-1:0] MIN_PERCENT  = 7'd20;

    // Phase arithmetic, 2^-32 turn units
    localparam logic [63:0] TURN         = 64'h1_0000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Q1.30 constants
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Exact truncating division by a constant for values below 2^30:
    // floor(v / d) = (v * ceil(2^(30+l) / d)) >> (30+l), l = ceil(log2(d))
    localparam logic [30:0] RECIP_42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
    localparam logic [30:0] RECIP_56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
    localparam logic [30:0] RECIP_20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
    localparam logic [30:0] RECIP_30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
    localparam logic [30:0] RECIP_6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
    localparam logic [30:0] RECIP_12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);

    // Coordinate placement: result = floor((N + 2^15*100) / (2^16*100))
    localparam logic [36:0] SUM_SCALE   = 37'd3276800;
    localparam logic [39:0] PLACE_ROUND = 40'd3276800;
    // floor(w / 100) for w below 2^22
    localparam logic [22:0] RECIP_100   = 23'(((64'd1 << 29) + 64'd99) / 64'd100);

    // One vertex travelling down the pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [PCT_W-1:0] k;
    } tag_t;

    // Per-shape values, lane 0 is x, lane 1 is y
    typedef struct packed {
        logic [1:0][COORD_W-1:0] lo;
        logic [1:0][COORD_W-1:0] hi;
        logic [1:0][COORD_W-1:0] span;
        logic [1:0][COORD_W:0]   sum;
        logic                    rect;
    } item_t;

    // Phase step 2^32 / n as quotient and remainder
    typedef struct packed {
        logic [31:0] quo;
        logic [4:0]  rem;
    } step_t;

    function automatic logic [29:0] mul_shr(input logic [29:0] v, input logic [30:0] m,
                                            input int unsigned sh);
        logic [60:0] p;
        p = 61'(v) * 61'(m);
        return 30'(p >> sh);
    endfunction

    function automatic step_t step_for(input logic [SIDES_W-1:0] n);
        step_t s;
        case (n)
            6'd3:    s = '{quo: 32'(TURN / 3),  rem: 5'(TURN % 3)};
            6'd4:    s = '{quo: 32'(TURN / 4),  rem: 5'(TURN % 4)};
            6'd5:    s = '{quo: 32'(TURN / 5),  rem: 5'(TURN % 5)};
            6'd6:    s = '{quo: 32'(TURN / 6),  rem: 5'(TURN % 6)};
            6'd7:    s = '{quo: 32'(TURN / 7),  rem: 5'(TURN % 7)};
            6'd8:    s = '{quo: 32'(TURN / 8),  rem: 5'(TURN % 8)};
            6'd9:    s = '{quo: 32'(TURN / 9),  rem: 5'(TURN % 9)};
            6'd10:   s = '{quo: 32'(TURN / 10), rem: 5'(TURN % 10)};
            6'd11:   s = '{quo: 32'(TURN / 11), rem: 5'(TURN % 11)};
            6'd12:   s = '{quo: 32'(TURN / 12), rem: 5'(TURN % 12)};
            6'd13:   s = '{quo: 32'(TURN / 13), rem: 5'(TURN % 13)};
            6'd14:   s = '{quo: 32'(TURN / 14), rem: 5'(TURN % 14)};
            6'd15:   s = '{quo: 32'(TURN / 15), rem: 5'(TURN % 15)};
            6'd16:   s = '{quo: 32'(TURN / 16), rem: 5'(TURN % 16)};
            6'd17:   s = '{quo: 32'(TURN / 17), rem: 5'(TURN % 17)};
            6'd18:   s = '{quo: 32'(TURN / 18), rem: 5'(TURN % 18)};
            6'd19:   s = '{quo: 32'(TURN / 19), rem: 5'(TURN % 19)};
            6'd20:   s = '{quo: 32'(TURN / 20), rem: 5'(TURN % 20)};
            6'd21:   s = '{quo: 32'(TURN / 21), rem: 5'(TURN % 21)};
            6'd22:   s = '{quo: 32'(TURN / 22), rem: 5'(TURN % 22)};
            6'd23:   s = '{quo: 32'(TURN / 23), rem: 5'(TURN % 23)};
            6'd24:   s = '{quo: 32'(TURN / 24), rem: 5'(TURN % 24)};
            6'd25:   s = '{quo: 32'(TURN / 25), rem: 5'(TURN % 25)};
            6'd26:   s = '{quo: 32'(TURN / 26), rem: 5'(TURN % 26)};
            6'd27:   s = '{quo: 32'(TURN / 27), rem: 5'(TURN % 27)};
            6'd28:   s = '{quo: 32'(TURN / 28), rem: 5'(TURN % 28)};
            6'd29:   s = '{quo: 32'(TURN / 29), rem: 5'(TURN % 29)};
            6'd30:   s = '{quo: 32'(TURN / 30), rem: 5'(TURN % 30)};
            6'd31:   s = '{quo: 32'(TURN / 31), rem: 5'(TURN % 31)};
            6'd32:   s = '{quo: 32'(TURN / 32), rem: 5'(TURN % 32)};
            default: s = '{quo: 32'd0, rem: 5'd0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/core/psvg_seq.sv]
// Configuration registers, command intake and per-vertex phase sequencer.
`default_nettype none

module psvg_seq import psvg_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   corner_a_x,
    input  logic [COORD_W-1:0]   corner_a_y,
    input  logic [COORD_W-1:0]   corner_b_x,
    input  logic [COORD_W-1:0]   corner_b_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [PCT_W-1:0]     cfg_data,
    input  logic                 done,
    output logic [31:0]          phase,
    output tag_t                 tag,
    output item_t                item
);

    logic [SIDES_W-1:0] side_count_reg;
    logic [PCT_W-1:0]   depth_reg;
    logic               busy_reg, busy_next;
    logic               issue_reg, issue_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [31:0]        acc_q_reg, acc_q_next;
    logic [SIDES_W-1:0] acc_r_reg, acc_r_next;
    logic [SIDES_W-1:0] n_reg;
    logic [PCT_W-1:0]   k_odd_reg;
    logic [31:0]        quo_reg;
    logic [4:0]         rem_reg;
    item_t              item_reg, item_next;

    logic               accept;
    logic               last;
    logic [SIDES_W-1:0] n_sat;
    logic [PCT_W-1:0]   k_odd;
    step_t              step_in;
    logic [SIDES_W-1:0] r_sum;
    logic               wrap;
    logic [1:0][COORD_W-1:0] a_in, b_in;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign last      = ({1'b0, idx_reg} == (n_reg - 6'd1));

    assign a_in = {corner_a_y, corner_a_x};
    assign b_in = {corner_b_y, corner_b_x};

    always_comb
    begin
        if (side_count_reg < 6'd3)
            n_sat = 6'd3;
        else if (side_count_reg > SIDES_W'(MAX_SIDES))
            n_sat = SIDES_W'(MAX_SIDES);
        else
            n_sat = side_count_reg;

        if (n_sat > 6'd4 && depth_reg < FULL_PERCENT)
            k_odd = (depth_reg < MIN_PERCENT) ? MIN_PERCENT : depth_reg;
        else
            k_odd = FULL_PERCENT;

        step_in = step_for(n_sat);

        for (int l = 0; l < 2; l++)
        begin
            item_next.lo[l]   = (a_in[l] < b_in[l]) ? a_in[l] : b_in[l];
            item_next.hi[l]   = (a_in[l] < b_in[l]) ? b_in[l] : a_in[l];
            item_next.span[l] = item_next.hi[l] - item_next.lo[l];
            item_next.sum[l]  = {1'b0, a_in[l]} + {1'b0, b_in[l]};
        end
        item_next.rect = (n_sat == 6'd4) && (depth_reg == FULL_PERCENT);
    end

    // Running division: acc_q*n + acc_r = i*2^32 + floor(n/2)
    always_comb
    begin
        r_sum = acc_r_reg + {1'b0, rem_reg};
        wrap  = (r_sum >= n_reg);

        busy_next  = busy_reg;
        issue_next = issue_reg;
        idx_next   = idx_reg;
        acc_q_next = acc_q_reg;
        acc_r_next = acc_r_reg;

        if (accept)
        begin
            busy_next  = 1'b1;
            issue_next = 1'b1;
            idx_next   = '0;
            acc_q_next = '0;
            acc_r_next = n_sat >> 1;
        end
        else
        begin
            if (done)
                busy_next = 1'b0;
            if (issue_reg)
            begin
                idx_next   = idx_reg + 5'd1;
                acc_q_next = acc_q_reg + quo_reg + {31'd0, wrap};
                acc_r_next = wrap ? (r_sum - n_reg) : r_sum;
                if (last)
                    issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= 6'd4;
            depth_reg      <= FULL_PERCENT;
            busy_reg       <= 1'b0;
            issue_reg      <= 1'b0;
            idx_reg        <= '0;
            acc_q_reg      <= '0;
            acc_r_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SIDE_COUNT: side_count_reg <= cfg_data[SIDES_W-1:0];
                    REG_STAR_DEPTH: depth_reg      <= cfg_data;
                    default: ;
                endcase
            end
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            idx_reg   <= idx_next;
            acc_q_reg <= acc_q_next;
            acc_r_reg <= acc_r_next;
        end
    end

    // Per-shape values, loaded on command acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg     <= n_sat;
            k_odd_reg <= k_odd;
            quo_reg   <= step_in.quo;
            rem_reg   <= step_in.rem;
            item_reg  <= item_next;
        end
    end

    assign phase     = acc_q_reg - QUARTER_TURN;
    assign tag.valid = issue_reg;
    assign tag.idx   = idx_reg;
    assign tag.last  = last;
    assign tag.k     = idx_reg[0] ? k_odd_reg : FULL_PERCENT;
    assign item      = item_reg;

endmodule

`default_nettype wire

[rtl/core/psvg_trig.sv]
// Pipelined sine/cosine unit: octant fold, polynomial chains, Q1.15 rounding and quadrant.
`default_nettype none

module psvg_trig import psvg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [31:0]              phase,
    input  tag_t                     tag_in,
    output tag_t                     tag_out,
    output logic [1:0][TRIG_W-1:0]   trig_out
);

    localparam int STAGES = 10;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } oct_t;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    tag_t              tag_reg [STAGES];
    oct_t              oct_reg [STAGES];
    logic [29:0]       u_reg;
    logic [29:0]       x_reg  [1:7];
    logic [29:0]       x2_reg [2:7];
    logic [1:0][30:0]  t1_reg, t2_reg, t3_reg;
    logic [1:0][29:0]  m1_reg, m2_reg;
    logic [29:0]       sin_v_reg;
    logic [30:0]       cos_v_reg;
    logic [1:0][TRIG_W-1:0] trig_reg;

    oct_t              oct_in;
    logic [29:0]       u_next;
    logic [1:0][30:0]  t1_next, t2_next, t3_next;
    logic [1:0][29:0]  m1_next, m2_next;
    logic [29:0]       sin_v_next;
    logic [30:0]       cos_v_next;
    logic [15:0]       sin_q, cos_q;
    logic signed [TRIG_W-1:0] sa, ca, s_val, c_val;

    // Fold: octant above the half quadrant mirrors and swaps sin/cos
    always_comb
    begin
        oct_in.quad = phase[31:30];
        oct_in.swap = phase[29];
        u_next = oct_in.swap ? 30'(Q30_ONE - {1'b0, phase[29:0]}) : phase[29:0];
    end

    always_comb
    begin
        // lane 0: sine chain, lane 1: cosine chain
        t1_next[0] = Q30_ONE - {1'b0, mul_shr(x2_reg[2], RECIP_42, 36)};
        t1_next[1] = Q30_ONE - {1'b0, mul_shr(x2_reg[2], RECIP_56, 36)};
        for (int l = 0; l < 2; l++)
        begin
            m1_next[l] = mul_shr(x2_reg[3], t1_reg[l], 30);
            m2_next[l] = mul_shr(x2_reg[5], t2_reg[l], 30);
        end
        t2_next[0] = Q30_ONE - {1'b0, mul_shr(m1_reg[0], RECIP_20, 35)};
        t2_next[1] = Q30_ONE - {1'b0, mul_shr(m1_reg[1], RECIP_30, 35)};
        t3_next[0] = Q30_ONE - {1'b0, mul_shr(m2_reg[0], RECIP_6, 33)};
        t3_next[1] = Q30_ONE - {1'b0, mul_shr(m2_reg[1], RECIP_12, 34)};
        sin_v_next = mul_shr(x_reg[7], t3_reg[0], 30);
        cos_v_next = Q30_ONE - {1'b0, mul_shr(x2_reg[7], t3_reg[1], 30) >> 1};
    end

    // Round to Q1.15 and apply the quadrant
    always_comb
    begin
        sin_q = 16'(({1'b0, sin_v_reg} + 31'd16384) >> 15);
        cos_q = 16'((cos_v_reg + 31'd16384) >> 15);
        sa = oct_reg[8].swap ? $signed({1'b0, cos_q}) : $signed({1'b0, sin_q});
        ca = oct_reg[8].swap ? $signed({1'b0, sin_q}) : $signed({1'b0, cos_q});
        case (quad_t'(oct_reg[8].quad))
            QUAD_I:
            begin
                s_val = sa;
                c_val = ca;
            end
            QUAD_II:
            begin
                s_val = ca;
                c_val = -sa;
            end
            QUAD_III:
            begin
                s_val = -sa;
                c_val = -ca;
            end
            default:
            begin
                s_val = -ca;
                c_val = sa;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < STAGES; j++)
                tag_reg[j] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int j = 1; j < STAGES; j++)
                tag_reg[j] <= tag_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        oct_reg[0] <= oct_in;
        for (int j = 1; j < STAGES; j++)
            oct_reg[j] <= oct_reg[j-1];
        u_reg     <= u_next;
        x_reg[1]  <= mul_shr(u_reg, HALF_PI_Q30, 30);
        for (int j = 2; j <= 7; j++)
            x_reg[j] <= x_reg[j-1];
        x2_reg[2] <= mul_shr(x_reg[1], {1'b0, x_reg[1]}, 30);
        for (int j = 3; j <= 7; j++)
            x2_reg[j] <= x2_reg[j-1];
        t1_reg    <= t1_next;
        m1_reg    <= m1_next;
        t2_reg    <= t2_next;
        m2_reg    <= m2_next;
        t3_reg    <= t3_next;
        sin_v_reg <= sin_v_next;
        cos_v_reg <= cos_v_next;
        trig_reg[0] <= c_val;
        trig_reg[1] <= s_val;
    end

    assign tag_out  = tag_reg[STAGES-1];
    assign trig_out = trig_reg;

endmodule

`default_nettype wire

[rtl/core/psvg_place.sv]
// Coordinate placement pipeline: scale by radius and percentage, round, rectangle override.
`default_nettype none

module psvg_place import psvg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tag_t                     tag_in,
    input  logic [1:0][TRIG_W-1:0]   trig_in,
    input  item_t                    item,
    output logic                     strobe,
    output logic [IDX_W-1:0]         vertex_number,
    output logic [COORD_W-1:0]       vertex_x,
    output logic [COORD_W-1:0]       vertex_y,
    output logic                     last_vertex
);

    tag_t                    tag_reg [3];
    logic signed [31:0]      tsp_reg  [2];
    logic signed [39:0]      prod_reg [2];
    logic [36:0]             base1_reg [2];
    logic [36:0]             base2_reg [2];
    logic [21:0]             w_reg [2];
    logic                    strobe_reg;
    logic [IDX_W-1:0]        number_reg;
    logic                    last_reg;
    logic [1:0][COORD_W-1:0] coord_reg;

    logic signed [31:0]      tsp_next  [2];
    logic [36:0]             base_next [2];
    logic signed [39:0]      prod_next [2];
    logic signed [40:0]      nsum      [2];
    logic [39:0]             npos      [2];
    logic [21:0]             w_next    [2];
    logic [44:0]             q_full    [2];
    logic [1:0][COORD_W-1:0] coord_next;
    logic                    x_high, y_high;

    always_comb
    begin
        x_high = tag_reg[2].idx[0] ^ tag_reg[2].idx[1];
        y_high = tag_reg[2].idx[1];
        for (int l = 0; l < 2; l++)
        begin
            tsp_next[l]  = 32'($signed(trig_in[l]) * $signed({1'b0, item.span[l]}));
            base_next[l] = 37'(item.sum[l]) * SUM_SCALE;
            prod_next[l] = 40'(tsp_reg[l] * $signed({1'b0, tag_reg[0].k}));
            nsum[l]      = $signed({4'b0000, base2_reg[l]}) + 41'(prod_reg[l]);
            npos[l]      = nsum[l][40] ? 40'd0 : nsum[l][39:0];
            w_next[l]    = 22'((npos[l] + PLACE_ROUND) >> 16);
            q_full[l]    = 45'(w_reg[l]) * 45'(RECIP_100);
        end
        // Rectangle corners go min/min, max/min, max/max, min/max
        if (item.rect)
        begin
            coord_next[0] = x_high ? item.hi[0] : item.lo[0];
            coord_next[1] = y_high ? item.hi[1] : item.lo[1];
        end
        else
        begin
            coord_next[0] = q_full[0][42:29];
            coord_next[1] = q_full[1][42:29];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 3; j++)
                tag_reg[j] <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= tag_reg[1];
            strobe_reg <= tag_reg[2].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            tsp_reg[l]   <= tsp_next[l];
            base1_reg[l] <= base_next[l];
            prod_reg[l]  <= prod_next[l];
            base2_reg[l] <= base1_reg[l];
            w_reg[l]     <= w_next[l];
        end
        number_reg <= tag_reg[2].idx;
        last_reg   <= tag_reg[2].last;
        coord_reg  <= coord_next;
    end

    assign strobe        = strobe_reg;
    assign vertex_number = number_reg;
    assign last_vertex   = last_reg;
    assign vertex_x      = coord_reg[0];
    assign vertex_y      = coord_reg[1];

endmodule

`default_nettype wire

[rtl/core/polygon_star_vertex_generator_unit.sv]
// Top level of the polygon/star vertex generator.
//
// Usage: write side_count (index 0) and star_depth_percent (index 1) on the
// cfg_valid/cfg_ready channel while the block is idle (cfg_ready = !busy).
// A command transaction takes place at a rising edge with start high and busy
// low; the four corner ports are sampled then. The block answers with one
// transaction per vertex: strobe is high for exactly one cycle with
// vertex_number, vertex_x, vertex_y and last_vertex, and the transaction
// completes at the edge that ends that cycle. Vertices leave in order, one
// per cycle, last_vertex marking the final one.
// The first vertex reaches the ports through the sequencer registers and the
// 14-stage sine/cosine and placement pipeline. Busy stays high until the
// transaction of the last vertex completes, and only then is the next command
// taken; one vertex enters the pipeline per cycle, so the vertex count sets
// the time per command. The receiver cannot stall, so no result is ever held
// back. Reset sets side_count to 4 and star_depth_percent to 100 and empties
// the pipeline; no clearing pass is needed.
`default_nettype none

module polygon_star_vertex_generator_unit import psvg_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   corner_a_x,
    input  logic [COORD_W-1:0]   corner_a_y,
    input  logic [COORD_W-1:0]   corner_b_x,
    input  logic [COORD_W-1:0]   corner_b_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [PCT_W-1:0]     cfg_data,
    output logic                 strobe,
    output logic [IDX_W-1:0]     vertex_number,
    output logic [COORD_W-1:0]   vertex_x,
    output logic [COORD_W-1:0]   vertex_y,
    output logic                 last_vertex
);

    logic                    done;
    logic [31:0]             phase;
    tag_t                    seq_tag;
    tag_t                    trig_tag;
    item_t                   item;
    logic [1:0][TRIG_W-1:0]  trig;

    assign done = strobe && last_vertex;

    psvg_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .corner_a_x (corner_a_x),
        .corner_a_y (corner_a_y),
        .corner_b_x (corner_b_x),
        .corner_b_y (corner_b_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .phase      (phase),
        .tag        (seq_tag),
        .item       (item)
    );

    psvg_trig u_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .phase    (phase),
        .tag_in   (seq_tag),
        .tag_out  (trig_tag),
        .trig_out (trig)
    );

    psvg_place u_place (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_in        (trig_tag),
        .trig_in       (trig),
        .item          (item),
        .strobe        (strobe),
        .vertex_number (vertex_number),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .last_vertex   (last_vertex)
    );

endmodule

`default_nettype wire
